@@ src/cfas_pkg.sv @@
// cfas_pkg: shared types and constants of the frame address successor
// no dependencies
package cfas_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned RowW    = 5;
  localparam int unsigned ColW    = 10;
  localparam int unsigned MinorW  = 7;
  localparam int unsigned LoadW   = 9;
  localparam int unsigned FrameW  = 8;
  localparam int unsigned RegW    = 4;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_COLS  = 2'd1,
    REQ_FRMS  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic {
    CFG_TOP_ROWS = 1'b0,
    CFG_BOT_ROWS = 1'b1
  } cfg_idx_e;

  localparam logic [KindW-1:0] KindNone = 2'd3;
  localparam logic [KindW-1:0] KindBram = 2'd1;
  localparam logic [KindW-1:0] KindCfg  = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic              half;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [MinorW-1:0] minor;
  } addr_t;

  typedef struct packed {
    logic row_ok;
    logic bus_ok;
    logic st_next;
    logic st_half;
    logic st_k1;
    logic st_k2;
  } flags_t;

endpackage

@@ src/config_frame_address_successor.sv @@
// config_frame_address_successor: geometry table and next frame address pipeline
// depends on cfas_pkg and cfas_ram
//
// Each request passes through the input register, table read, step decision and output
// register before its answer is presented; a new request is taken every cycle while the
// output is not stalled. Query requests give one answer each; column and frame count loads
// give none and are written to the tables as they leave the input register, so a following
// query sees them. Tables: a column count memory and two copies of the frame count
// memory (current and next column), plus per-bus flags marking a non-empty bus whose
// first column has frames.
module config_frame_address_successor #(
  parameter int unsigned MAX_ROWS    = 8,
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_FRAMES  = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cfas_pkg::RegW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // kind[1:0], half[2], row[7:3], column[17:8], minor[24:18], load value[33:25]
  input  logic [cfas_pkg::InDataW-1:0]  s_axis_tdata,
  // request type[1:0]
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // kind[1:0], half[2], row[7:3], column[17:8], minor[24:18]
  output logic [cfas_pkg::OutDataW-1:0] m_axis_tdata,
  // found[0]
  output logic                          m_axis_tuser
);
  import cfas_pkg::*;

  localparam int unsigned Slots  = 6 * MAX_ROWS;
  localparam int unsigned SW     = $clog2(Slots);
  localparam int unsigned FDepth = Slots * MAX_COLUMNS;
  localparam int unsigned FAW    = $clog2(FDepth);
  localparam int unsigned CCW    = $clog2(MAX_COLUMNS + 1) > LoadW ?
                                   $clog2(MAX_COLUMNS + 1) : LoadW;
  localparam int unsigned NW     = CCW > ColW ? CCW + 1 : ColW + 1;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [RegW-1:0] top_q, bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      bot_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TOP_ROWS: top_q <= cfg_data_i;
        CFG_BOT_ROWS: bot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: registered request
  logic              v1_q;
  logic [1:0]        req1_q;
  addr_t             a1_q;
  logic [LoadW-1:0]  ld1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      req1_q      <= s_axis_tuser;
      a1_q.kind   <= s_axis_tdata[1:0];
      a1_q.half   <= s_axis_tdata[2];
      a1_q.row    <= s_axis_tdata[7:3];
      a1_q.col    <= s_axis_tdata[17:8];
      a1_q.minor  <= s_axis_tdata[24:18];
      ld1_q       <= s_axis_tdata[33:25];
    end
  end

  logic [5:0] rows_top, rows_bot, rows_h;
  assign rows_top = (6'(top_q) > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : 6'(top_q);
  assign rows_bot = (6'(bot_q) > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : 6'(bot_q);
  assign rows_h   = a1_q.half ? rows_bot : rows_top;

  logic          kind_ok, slot_ok;
  logic [SW-1:0] slot, slot_n, slot_h, slot_k1, slot_k2;
  logic [FAW-1:0] fa0, fa1;

  assign kind_ok = a1_q.kind != KindNone;
  assign slot_ok = kind_ok && (6'(a1_q.row) < 6'(MAX_ROWS));
  assign slot    = SW'({a1_q.kind, a1_q.half} * MAX_ROWS + a1_q.row);
  assign slot_n  = SW'({a1_q.kind, a1_q.half} * MAX_ROWS + a1_q.row + 1);
  assign slot_h  = SW'({a1_q.kind, 1'b1} * MAX_ROWS);
  assign slot_k1 = SW'(2 * MAX_ROWS);
  assign slot_k2 = SW'(4 * MAX_ROWS);
  assign fa0     = FAW'(slot * MAX_COLUMNS + a1_q.col);
  assign fa1     = FAW'(slot * MAX_COLUMNS + a1_q.col + 1);

  logic [CCW-1:0]    col_sat;
  logic [FrameW-1:0] frm_sat;
  logic              we_col, we_frm;

  assign col_sat = (CCW'(ld1_q) > CCW'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS) : CCW'(ld1_q);
  assign frm_sat = (10'(ld1_q) > 10'(MAX_FRAMES)) ? FrameW'(MAX_FRAMES)
                                                  : FrameW'(ld1_q);
  assign we_col  = en && v1_q && (req_e'(req1_q) == REQ_COLS) && slot_ok;
  assign we_frm  = en && v1_q && (req_e'(req1_q) == REQ_FRMS) && slot_ok &&
                   (11'(a1_q.col) < 11'(MAX_COLUMNS));

  // bus non-empty and first column non-empty
  logic [Slots-1:0] cnz_q, fnz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnz_q <= '0;
      fnz_q <= '0;
    end else begin
      if (we_col) begin
        cnz_q[slot] <= col_sat != '0;
      end
      if (we_frm && a1_q.col == '0) begin
        fnz_q[slot] <= frm_sat != '0;
      end
    end
  end

  logic [CCW-1:0]    nc2;
  logic [FrameW-1:0] fc0_2, fc1_2;

  cfas_ram #(.WIDTH(CCW), .DEPTH(Slots)) u_cols (
    .clk_i, .we_i(we_col), .waddr_i(slot), .wdata_i(col_sat),
    .re_i(en), .raddr_i(slot), .rdata_o(nc2)
  );

  cfas_ram #(.WIDTH(FrameW), .DEPTH(FDepth)) u_frm_cur (
    .clk_i, .we_i(we_frm), .waddr_i(fa0), .wdata_i(frm_sat),
    .re_i(en), .raddr_i(fa0), .rdata_o(fc0_2)
  );

  cfas_ram #(.WIDTH(FrameW), .DEPTH(FDepth)) u_frm_nxt (
    .clk_i, .we_i(we_frm), .waddr_i(fa0), .wdata_i(frm_sat),
    .re_i(en), .raddr_i(fa1), .rdata_o(fc1_2)
  );

  flags_t fl1;
  assign fl1.row_ok  = 6'(a1_q.row) < rows_h;
  assign fl1.bus_ok  = slot_ok && cnz_q[slot];
  assign fl1.st_next = kind_ok && (6'(a1_q.row) + 6'd1 < rows_h) &&
                       cnz_q[slot_n] && fnz_q[slot_n];
  assign fl1.st_half = !a1_q.half && kind_ok && (rows_bot != '0) &&
                       cnz_q[slot_h] && fnz_q[slot_h];
  assign fl1.st_k1   = (a1_q.kind < KindBram) && (rows_top != '0) &&
                       cnz_q[slot_k1] && fnz_q[slot_k1];
  assign fl1.st_k2   = (a1_q.kind < KindCfg) && (rows_top != '0) &&
                       cnz_q[slot_k2] && fnz_q[slot_k2];

  // stage 2: table data
  logic   v2_q;
  addr_t  a2_q;
  flags_t fl2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q && (req_e'(req1_q) == REQ_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q  <= a1_q;
      fl2_q <= fl1;
    end
  end

  logic col_ok, step_m, step_c;
  assign col_ok = fl2_q.row_ok && fl2_q.bus_ok && (NW'(a2_q.col) < NW'(nc2));
  assign step_m = col_ok && (9'(a2_q.minor) + 9'd1 < 9'(fc0_2));
  assign step_c = col_ok && (NW'(a2_q.col) + NW'(1) < NW'(nc2)) && (fc1_2 != '0);

  // stage 3: step decision
  logic   v3_q, sm3_q, sc3_q;
  addr_t  a3_q;
  flags_t fl3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q  <= a2_q;
      fl3_q <= fl2_q;
      sm3_q <= step_m;
      sc3_q <= step_c;
    end
  end

  addr_t nxt;
  logic  fnd;

  always_comb begin
    nxt = '0;
    fnd = 1'b1;
    if (sm3_q) begin
      nxt       = a3_q;
      nxt.minor = a3_q.minor + MinorW'(1);
    end else if (sc3_q) begin
      nxt       = a3_q;
      nxt.col   = a3_q.col + ColW'(1);
      nxt.minor = '0;
    end else if (fl3_q.st_next) begin
      nxt.kind = a3_q.kind;
      nxt.half = a3_q.half;
      nxt.row  = a3_q.row + RowW'(1);
    end else if (fl3_q.st_half) begin
      nxt.kind = a3_q.kind;
      nxt.half = 1'b1;
    end else if (fl3_q.st_k1) begin
      nxt.kind = KindBram;
    end else if (fl3_q.st_k2) begin
      nxt.kind = KindCfg;
    end else begin
      fnd = 1'b0;
    end
  end

  // output register
  logic  mv_q, fnd_q;
  addr_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en) begin
      mv_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= nxt;
      fnd_q <= fnd;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser  = fnd_q;
  assign m_axis_tdata  = {7'd0, out_q.minor, out_q.col, out_q.row, out_q.half, out_q.kind};

endmodule

@@ src/cfas_ram.sv @@
// cfas_ram: generic single write, single read memory with registered read
// no dependencies
module cfas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for config_frame_address_successor
// depends on cfas_pkg and the block's rtl; predicts each query answer from a local geometry table

class successor_board;
  int unsigned top_count, bot_count;
  int unsigned cols_tab [48];
  int unsigned frm_tab [48*256];
  bit [255:0] frm_set [48];
  logic [32:0] pending_q [$];
  int unsigned mismatches;

  function new();
    top_count = 0; bot_count = 0; mismatches = 0;
    foreach (cols_tab[i]) cols_tab[i] = 0;
    foreach (frm_tab[i]) frm_tab[i] = 0;
    foreach (frm_set[i]) frm_set[i] = '0;
  endfunction

  function int unsigned rows_of(int unsigned h);
    int unsigned n;
    n = (h != 0) ? bot_count : top_count;
    return n > 8 ? 8 : n;
  endfunction

  function int slot(int unsigned k, int unsigned h, int unsigned r);
    if (k >= 3 || r >= 8) return -1;
    return (k * 2 + h) * 8 + r;
  endfunction

  function int unsigned cols(int unsigned k, int unsigned h, int unsigned r);
    int b;
    b = slot(k, h, r);
    return b < 0 ? 0 : cols_tab[b];
  endfunction

  function int unsigned frms(int unsigned k, int unsigned h, int unsigned r,
                             int unsigned c);
    int b;
    b = slot(k, h, r);
    if (b < 0 || c >= 256) return 0;
    return frm_tab[b * 256 + c];
  endfunction

  function bit starts(int unsigned k, int unsigned h, int unsigned r);
    return r < rows_of(h) && cols(k, h, r) > 0 && frms(k, h, r, 0) > 0;
  endfunction

  // packed as {found, 7'b0, minor, col, row, half, kind} within 33 bits
  function logic [32:0] pack(int unsigned k, int unsigned h, int unsigned r,
                             int unsigned c, int unsigned m);
    logic [31:0] d;
    d = '0;
    d[1:0] = 2'(k); d[2] = h[0]; d[7:3] = 5'(r); d[17:8] = 10'(c); d[24:18] = 7'(m);
    return {1'b1, d};
  endfunction

  function logic [32:0] successor(int unsigned k, int unsigned h, int unsigned r,
                                  int unsigned c, int unsigned m);
    int unsigned nc, fc;
    if (r < rows_of(h)) begin
      nc = cols(k, h, r);
      if (nc > 0 && c < nc) begin
        fc = frms(k, h, r, c);
        if (m + 1 < fc) return pack(k, h, r, c, m + 1);
        if (c + 1 < nc && frms(k, h, r, c + 1) > 0) return pack(k, h, r, c + 1, 0);
      end
      if (r + 1 < rows_of(h) && starts(k, h, r + 1)) return pack(k, h, r + 1, 0, 0);
    end
    if (h == 0 && starts(k, 1, 0)) return pack(k, 1, 0, 0, 0);
    if (k < 1 && starts(1, 0, 0)) return pack(1, 0, 0, 0, 0);
    if (k < 2 && starts(2, 0, 0)) return pack(2, 0, 0, 0, 0);
    return '0;
  endfunction

  function void note_request(logic [1:0] req, logic [39:0] d);
    int unsigned k, h, r, c, m, v;
    int b;
    k = 32'(d[1:0]); h = 32'(d[2]); r = 32'(d[7:3]); c = 32'(d[17:8]);
    m = 32'(d[24:18]); v = 32'(d[33:25]);
    b = slot(k, h, r);
    case (req)
      cfas_pkg::REQ_COLS: begin
        if (b >= 0) cols_tab[b] = v > 256 ? 256 : v;
      end
      cfas_pkg::REQ_FRMS: begin
        if (b >= 0 && c < 256) begin
          frm_tab[b * 256 + c] = v > 128 ? 128 : v;
          frm_set[b][c] = 1'b1;
        end
      end
      cfas_pkg::REQ_QUERY: pending_q.push_back(successor(k, h, r, c, m));
      default: ;
    endcase
  endfunction

  function void check_answer(logic found, logic [31:0] d);
    logic [32:0] want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected answer found=%0b data=%h", found, d);
      return;
    end
    want = pending_q.pop_front();
    if (want !== {found, d}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected found=%0b data=%h, got found=%0b data=%h",
                 want[32], want[31:0], found, d);
    end
  endfunction
endclass

module tb;
  import cfas_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [RegW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  successor_board board = new();
  int unsigned send_idle, recv_idle;

  config_frame_address_successor DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_answer(m_axis_tuser, m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // leaves the request valid after acceptance; the next send replaces or drops it, drain drops it
  task automatic send(logic [1:0] req, int unsigned k, int unsigned h, int unsigned r,
                      int unsigned c, int unsigned m, int unsigned v);
    logic [InDataW-1:0] d;
    d = '0;
    d[1:0] = 2'(k); d[2] = h[0]; d[7:3] = 5'(r); d[17:8] = 10'(c);
    d[24:18] = 7'(m); d[33:25] = 9'(v);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(req, d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_rows(int unsigned top, int unsigned bot);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_TOP_ROWS; cfg_data_i <= RegW'(top);
    @(posedge clk_i);
    cfg_idx_i <= CFG_BOT_ROWS; cfg_data_i <= RegW'(bot);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.top_count = top; board.bot_count = bot;
  endtask

  function automatic bit bus_safe(int unsigned k, int unsigned h, int unsigned r);
    int b;
    b = board.slot(k, h, r);
    if (b < 0 || r >= board.rows_of(h) || board.cols_tab[b] == 0) return 1;
    return board.frm_set[b][0];
  endfunction

  function automatic bit query_safe(int unsigned k, int unsigned h, int unsigned r,
                                    int unsigned c);
    int b;
    b = board.slot(k, h, r);
    if (!bus_safe(k, 1, 0) || !bus_safe(1, 0, 0) || !bus_safe(2, 0, 0)) return 0;
    if (b < 0 || r >= board.rows_of(h)) return 1;
    if (r + 1 < board.rows_of(h) && !bus_safe(k, h, r + 1)) return 0;
    if (c < board.cols_tab[b]) begin
      if (!board.frm_set[b][c]) return 0;
      if (c + 1 < board.cols_tab[b] && !board.frm_set[b][c + 1]) return 0;
    end
    return 1;
  endfunction

  // query that never reads an unwritten frame count
  task automatic random_query();
    int unsigned k, h, r, c, m, tries;
    tries = 0;
    do begin
      k = $urandom_range(3); h = $urandom_range(1);
      r = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(8);
      c = ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(5);
      m = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(4);
      tries++;
    end while (!query_safe(k, h, r, c) && tries < 50);
    if (query_safe(k, h, r, c)) send(REQ_QUERY, k, h, r, c, m, $urandom_range(511));
  endtask

  // fill a whole geometry with small random counts
  task automatic load_geometry();
    for (int k = 0; k < 3; k++)
      for (int h = 0; h < 2; h++)
        for (int r = 0; r < 8; r++) begin
          int unsigned n;
          n = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4);
          send(REQ_COLS, k, h, r, $urandom_range(1023), $urandom_range(127), n);
          for (int c = 0; c < n; c++)
            send(REQ_FRMS, k, h, r, c, $urandom_range(127),
                 ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 3));
        end
  endtask

  initial begin
    #200000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_top [4] = '{8, 15, 0, 3};
    int unsigned phase_bot [4] = '{8, 0, 15, 5};
    send_idle = 24; recv_idle = 68;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty device, odd requests, saturating loads, edges of a column
    send(REQ_QUERY, 0, 0, 0, 0, 0, 0);
    send(REQ_QUERY, 3, 1, 31, 1023, 127, 511);
    send(REQ_NONE, 0, 0, 0, 0, 0, 0);
    send(REQ_COLS, 3, 0, 0, 0, 0, 5);
    send(REQ_COLS, 0, 0, 9, 0, 0, 5);
    send(REQ_FRMS, 0, 0, 0, 300, 0, 5);
    drain();
    set_rows(2, 1);
    send(REQ_COLS, 0, 0, 0, 0, 0, 511);
    for (int c = 0; c < 256; c++) send(REQ_FRMS, 0, 0, 0, c, 0, (c == 0) ? 511 : 2);
    send(REQ_COLS, 0, 0, 1, 0, 0, 1);
    send(REQ_FRMS, 0, 0, 1, 0, 0, 1);
    send(REQ_COLS, 0, 1, 0, 0, 0, 1);
    send(REQ_FRMS, 0, 1, 0, 0, 0, 3);
    send(REQ_COLS, 1, 0, 0, 0, 0, 1);
    send(REQ_FRMS, 1, 0, 0, 0, 0, 1);
    send(REQ_QUERY, 0, 0, 0, 0, 126, 0);
    send(REQ_QUERY, 0, 0, 0, 0, 127, 0);
    send(REQ_QUERY, 0, 0, 0, 255, 1, 0);
    send(REQ_QUERY, 0, 0, 1, 0, 0, 0);
    send(REQ_QUERY, 0, 1, 0, 0, 2, 0);
    send(REQ_QUERY, 1, 0, 0, 0, 0, 0);
    send(REQ_QUERY, 3, 0, 0, 0, 0, 0);
    send(REQ_QUERY, 0, 0, 31, 1023, 127, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      if (p == 1) begin send_idle = 68; recv_idle = 24; end
      if (p >= 2) begin send_idle = 0; recv_idle = 0; end
      set_rows(phase_top[p], phase_bot[p]);
      load_geometry();
      for (int i = 0; i < 260; i++) begin
        if ($urandom_range(15) == 0)
          send($urandom_range(3) == 0 ? REQ_NONE : REQ_COLS, $urandom_range(3),
               $urandom_range(1), $urandom_range(31), $urandom_range(1023),
               $urandom_range(127), 0);
        else
          random_query();
      end
      drain();
    end

    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ config_frame_address_successor.f @@
src/cfas_pkg.sv
src/cfas_ram.sv
src/config_frame_address_successor.sv
tb/tb.sv
